[src/bts_pkg.sv]
// ----------------------------------------------------------------------------
// bts_pkg
// Shared widths, defaults and codes for the bilinear texture sampler.
// ----------------------------------------------------------------------------
package bts_pkg;

  // Parameter defaults
  localparam int MAX_DIM_DEF   = 256;
  localparam int FRAC_BITS_DEF = 16;

  // Texel store
  localparam int STORE_DEPTH = 65536;
  localparam int ADDR_W      = 16;
  localparam int TEXEL_W     = 32;

  // Field widths
  localparam int DIM_W   = 9;
  localparam int COORD_W = 17;
  localparam int CHAN_W  = 2;
  localparam int LEVEL_W = 24;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

  // Register indexes (byte address bit 2)
  localparam logic REG_TEX_WIDTH  = 1'b0;
  localparam logic REG_TEX_HEIGHT = 1'b1;

  // Item opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

endpackage

[src/bts_ram.sv]
// ----------------------------------------------------------------------------
// bts_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module bts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[src/bilinear_texture_sampler.sv]
// ----------------------------------------------------------------------------
// bilinear_texture_sampler
// Write word: stored at the edge it is accepted; one write per cycle while no sample is in progress.
// Sample word: passes the multiply, map and row states, then four serial reads
// of the single-port texel store feed the weight, multiply and accumulate
// registers; no word is taken until the level is loaded into the output register.
// Reset clears control state and sets both dimensions to 256; the texel store
// is not cleared.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler #(
  parameter int MAX_DIM   = bts_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = bts_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bts_pkg::PADDR_W-1:0]  paddr,
  input  logic [bts_pkg::PDATA_W-1:0]  pwdata,
  output logic [bts_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         opcode,
  input  logic [bts_pkg::ADDR_W-1:0]   texel_index,
  input  logic [bts_pkg::TEXEL_W-1:0]  texel_rgba,
  input  logic [bts_pkg::COORD_W-1:0]  coord_u,
  input  logic [bts_pkg::COORD_W-1:0]  coord_v,
  input  logic [bts_pkg::CHAN_W-1:0]   channel_select,
  // output channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bts_pkg::LEVEL_W-1:0]  filtered_level
);

  import bts_pkg::*;

  localparam int F     = FRAC_BITS;
  localparam int PRODW = COORD_W + DIM_W;
  localparam int UP    = (F > 16) ? F - 16 : 0;
  localparam int DOWN  = (F < 16) ? 16 - F : 0;
  localparam int PW    = PRODW + UP;
  localparam int XW    = DIM_W + F;
  localparam int CW    = (PW > XW) ? PW : XW;
  localparam int WW    = F + 1;
  localparam int GW    = 2 * WW;
  localparam int AW    = 2 * F + 10;
  localparam int SH    = 2 * F - 16;
  localparam int BW    = 2 * DIM_W;

  localparam logic [CW-1:0] HALF = CW'(1) << (F - 1);
  localparam logic [WW-1:0] ONE  = WW'(1) << F;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL   = 7'b0000010,
    ST_MAP   = 7'b0000100,
    ST_ROW   = 7'b0001000,
    ST_READ  = 7'b0010000,
    ST_DRAIN = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  // Map a Q16 coordinate product to clamped texel space with F fraction bits.
  function automatic logic [XW-1:0] to_texel(input logic [PRODW-1:0] prod,
                                             input logic [DIM_W-1:0] dim);
    logic [CW-1:0] p;
    logic [CW-1:0] top;
    logic [CW-1:0] r;
    p   = (CW'(prod) << UP) >> DOWN;
    top = CW'(dim - 9'd1) << F;
    if (p < HALF) begin
      r = '0;
    end else begin
      p = p - HALF;
      r = (p > top) ? top : p;
    end
    return XW'(r);
  endfunction

  // Zero acts as one, anything past MAX_DIM saturates.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (32'(d) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

  // configuration registers
  logic [DIM_W-1:0] tex_width;
  logic [DIM_W-1:0] tex_height;

  // control
  state_t      state;
  logic [1:0]  tap;
  logic        s1_valid;
  logic        s2_valid;

  // sample payload
  logic [COORD_W-1:0] u_q;
  logic [COORD_W-1:0] v_q;
  logic [CHAN_W-1:0]  ch_q;
  logic [DIM_W-1:0]   w_q;
  logic [DIM_W-1:0]   h_q;
  logic [PRODW-1:0]   prod_x;
  logic [PRODW-1:0]   prod_y;
  logic               y_zero;
  logic [DIM_W-1:0]   a;
  logic [DIM_W-1:0]   b;
  logic [DIM_W-1:0]   a1;
  logic [F-1:0]       fx;
  logic [F-1:0]       fy;
  logic [BW-1:0]      base0;
  logic [BW-1:0]      base1;
  logic [GW-1:0]      wgt;
  logic [AW-1:0]      prod;
  logic [AW-1:0]      acc;

  // combinational
  logic               in_fire;
  logic               cfg_write;
  logic               out_load;
  logic [XW-1:0]      x_map;
  logic [XW-1:0]      y_map;
  logic [DIM_W-1:0]   b1;
  logic [WW-1:0]      wx;
  logic [WW-1:0]      wy;
  logic [BW:0]        tap_sum;
  logic [ADDR_W-1:0]  ram_addr;
  logic               ram_we;
  logic [TEXEL_W-1:0] ram_rdata;
  logic [7:0]         lvl;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign out_load  = (state == ST_DONE) & (~out_valid | out_ready);

  always_comb begin
    unique case (paddr[2])
      REG_TEX_WIDTH:  prdata = PDATA_W'(tex_width);
      REG_TEX_HEIGHT: prdata = PDATA_W'(tex_height);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= DIM_RESET;
      tex_height <= DIM_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_TEX_WIDTH:  tex_width  <= pwdata[DIM_W-1:0];
        REG_TEX_HEIGHT: tex_height <= pwdata[DIM_W-1:0];
        default:        ;
      endcase
    end
  end

  // texel store access: writes straight from the input word, reads per tap
  assign x_map   = to_texel(prod_x, w_q);
  assign y_map   = y_zero ? '0 : to_texel(prod_y, h_q);
  assign b1      = (b == h_q - 9'd1) ? b : b + 9'd1;
  assign wx      = tap[0] ? {1'b0, fx} : ONE - {1'b0, fx};
  assign wy      = tap[1] ? {1'b0, fy} : ONE - {1'b0, fy};
  assign tap_sum = {1'b0, (tap[1] ? base1 : base0)} + (BW + 1)'(tap[0] ? a1 : a);
  assign ram_we  = in_fire & (opcode == OP_WRITE);
  assign ram_addr = (state == ST_IDLE) ? texel_index : tap_sum[ADDR_W-1:0];
  assign lvl     = 8'(ram_rdata >> {ch_q, 3'b000});

  bts_ram #(
    .WIDTH (TEXEL_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (texel_rgba),
    .rdata (ram_rdata)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tap       <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= (state == ST_READ);
      s2_valid <= s1_valid;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire && opcode == OP_SAMPLE) begin
            state <= ST_MUL;
          end
        end
        ST_MUL:  state <= ST_MAP;
        ST_MAP:  state <= ST_ROW;
        ST_ROW: begin
          tap   <= '0;
          state <= ST_READ;
        end
        ST_READ: begin
          tap <= tap + 2'd1;
          if (tap == 2'd3) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // wait for the last tap to reach the accumulator
          if (!s1_valid && !s2_valid) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      u_q  <= coord_u;
      v_q  <= coord_v;
      ch_q <= channel_select;
      w_q  <= eff_dim(tex_width);
      h_q  <= eff_dim(tex_height);
    end
    if (state == ST_MUL) begin
      prod_x <= PRODW'(u_q * w_q);
      prod_y <= PRODW'((COORD_W'(65536) - v_q) * h_q);
      y_zero <= v_q[COORD_W-1];
      acc    <= '0;
    end
    if (state == ST_MAP) begin
      a  <= x_map[XW-1:F];
      fx <= x_map[F-1:0];
      b  <= y_map[XW-1:F];
      fy <= y_map[F-1:0];
    end
    if (state == ST_ROW) begin
      a1    <= (a == w_q - 9'd1) ? a : a + 9'd1;
      base0 <= b * w_q;
      base1 <= b1 * w_q;
    end
    if (state == ST_READ) begin
      wgt <= wx * wy;
    end
    if (s1_valid) begin
      prod <= AW'(lvl * wgt);
    end
    if (s2_valid) begin
      acc <= acc + prod;
    end
    if (out_load) begin
      filtered_level <= LEVEL_W'(acc >> SH);
    end
  end

endmodule

[tb/bilinear_texture_sampler_test.sv]
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_test
// Loads texels and requests filtered samples under a range of texture sizes,
// including zero and oversize dimensions. Each sample is predicted from a
// shadow copy of the texel store and compared with the returned level, with
// random gaps on the input and random back-pressure on the output.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_test;
  import bts_pkg::*;

  localparam int FRAC        = FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 16;
  localparam int PHASE_WORDS = 52;

  typedef struct {
    logic                op;
    logic [ADDR_W-1:0]   index;
    logic [TEXEL_W-1:0]  rgba;
    logic [COORD_W-1:0]  u;
    logic [COORD_W-1:0]  v;
    logic [CHAN_W-1:0]   chan;
  } texel_word_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                opcode = OP_WRITE;
  logic [ADDR_W-1:0]   texel_index = '0;
  logic [TEXEL_W-1:0]  texel_rgba = '0;
  logic [COORD_W-1:0]  coord_u = '0;
  logic [COORD_W-1:0]  coord_v = '0;
  logic [CHAN_W-1:0]   channel_select = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [LEVEL_W-1:0]  filtered_level;

  bilinear_texture_sampler dut (.*);

  always #10 clk = ~clk;

  // shadow texel store and dimension registers
  bit [TEXEL_W-1:0]    texel_mem [STORE_DEPTH];
  bit                  written_map [STORE_DEPTH];
  logic [DIM_W-1:0]    cfg_width = DIM_RESET;
  logic [DIM_W-1:0]    cfg_height = DIM_RESET;

  texel_word_t         texel_ops [$];
  logic [LEVEL_W-1:0]  expected_levels [$];

  int unsigned words_queued = 0;
  int unsigned words_taken = 0;
  int unsigned samples_checked = 0;
  int unsigned writes_taken = 0;
  int unsigned mismatches = 0;
  int unsigned settings_run = 1;
  int unsigned cycles = 0;
  bit          steady = 1'b0;
  bit          in_taken = 1'b0;

  function automatic int unsigned eff_dim(logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
    return 32'(d);
  endfunction

  // Rescale a Q16 product to the grid, take off half a texel and clamp.
  function automatic longint unsigned grid_pos(longint unsigned prod16, int unsigned dim);
    longint unsigned p;
    longint unsigned half;
    longint unsigned top;
    half = 64'd1 << (FRAC - 1);
    top = 64'(dim - 1) << FRAC;
    if (FRAC >= 16) p = prod16 << (FRAC - 16);
    else p = prod16 >> (16 - FRAC);
    if (p < half) return 0;
    p -= half;
    return (p > top) ? top : p;
  endfunction

  function automatic void locate(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v,
                                 output int unsigned a, output int unsigned b,
                                 output longint unsigned fx, output longint unsigned fy);
    int unsigned w;
    int unsigned h;
    longint unsigned x;
    longint unsigned y;
    w = eff_dim(cfg_width);
    h = eff_dim(cfg_height);
    x = grid_pos(64'(u) * w, w);
    // v at or past 1.0 pins y to the top row
    y = (v >= 17'h10000) ? 0 : grid_pos(64'(17'h10000 - v) * h, h);
    a = 32'(x >> FRAC);
    b = 32'(y >> FRAC);
    fx = x & ((64'd1 << FRAC) - 1);
    fy = y & ((64'd1 << FRAC) - 1);
  endfunction

  function automatic logic [ADDR_W-1:0] corner_addr(int unsigned a, int unsigned b,
                                                    int unsigned dx, int unsigned dy);
    int unsigned w;
    int unsigned h;
    int unsigned xx;
    int unsigned yy;
    w = eff_dim(cfg_width);
    h = eff_dim(cfg_height);
    xx = (a + dx > w - 1) ? w - 1 : a + dx;
    yy = (b + dy > h - 1) ? h - 1 : b + dy;
    return ADDR_W'(yy * w + xx);
  endfunction

  function automatic logic [LEVEL_W-1:0] bilinear_level(logic [COORD_W-1:0] u,
                                                       logic [COORD_W-1:0] v,
                                                       logic [CHAN_W-1:0] chan);
    int unsigned a;
    int unsigned b;
    longint unsigned fx;
    longint unsigned fy;
    longint unsigned one;
    longint unsigned wx;
    longint unsigned wy;
    longint unsigned lvl;
    longint unsigned sum;
    one = 64'd1 << FRAC;
    locate(u, v, a, b, fx, fy);
    sum = 0;
    for (int dy = 0; dy < 2; dy++) begin
      for (int dx = 0; dx < 2; dx++) begin
        lvl = 64'(8'(texel_mem[corner_addr(a, b, dx, dy)] >> (8 * chan)));
        wx = (dx != 0) ? fx : one - fx;
        wy = (dy != 0) ? fy : one - fy;
        sum += lvl * wx * wy;
      end
    end
    return LEVEL_W'(sum >> (2 * FRAC - 16));
  endfunction

  function automatic bit take_break();
    return !steady && ($urandom_range(99) < 16);
  endfunction

  function automatic logic [TEXEL_W-1:0] pick_texel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(11))
      0: return '0;
      1: return 17'h10000;
      2: return 17'h1FFFF;
      3, 4: return COORD_W'($urandom_range(17'h1FFFF));
      default: return COORD_W'($urandom_range(17'h10000));
    endcase
  endfunction

  task automatic queue_write(logic [ADDR_W-1:0] addr, logic [TEXEL_W-1:0] rgba);
    texel_word_t wd;
    wd.op = OP_WRITE;
    wd.index = addr;
    wd.rgba = rgba;
    // coordinates and channel are don't-care on a write
    wd.u = COORD_W'($urandom());
    wd.v = COORD_W'($urandom());
    wd.chan = CHAN_W'($urandom());
    written_map[addr] = 1'b1;
    texel_ops.push_back(wd);
    words_queued++;
  endtask

  // Load any corner not yet written (refresh some at random), then sample.
  task automatic queue_sample(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v,
                              logic [CHAN_W-1:0] chan);
    texel_word_t wd;
    int unsigned a;
    int unsigned b;
    longint unsigned fx;
    longint unsigned fy;
    logic [ADDR_W-1:0] addr;
    locate(u, v, a, b, fx, fy);
    for (int k = 0; k < 4; k++) begin
      addr = corner_addr(a, b, k % 2, k / 2);
      if (!written_map[addr] || $urandom_range(3) == 0) queue_write(addr, pick_texel());
    end
    wd.op = OP_SAMPLE;
    wd.index = ADDR_W'($urandom());
    wd.rgba = $urandom();
    wd.u = u;
    wd.v = v;
    wd.chan = chan;
    texel_ops.push_back(wd);
    words_queued++;
  endtask

  task automatic queue_random(int unsigned n);
    int unsigned stop;
    stop = words_queued + n;
    while (words_queued < stop) begin
      if ($urandom_range(5) == 0) queue_write(ADDR_W'($urandom()), pick_texel());
      else queue_sample(pick_coord(), pick_coord(), CHAN_W'($urandom()));
    end
  endtask

  task automatic write_reg(logic reg_idx, logic [DIM_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {reg_idx, 2'b00};
    pwdata <= {23'($urandom()), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == REG_TEX_WIDTH) cfg_width = value;
    else cfg_height = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Wait until every word is taken and every level returned, then let it settle.
  task automatic drain();
    while (words_taken != words_queued || expected_levels.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic run_setting(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    write_reg(REG_TEX_WIDTH, w);
    write_reg(REG_TEX_HEIGHT, h);
    settings_run++;
    @(posedge clk);
    queue_random(PHASE_WORDS);
    drain();
  endtask

  // input driver
  always @(negedge clk) begin
    texel_word_t wd;
    if (!rst && (!in_valid || in_taken)) begin
      if (texel_ops.size() != 0 && !take_break()) begin
        wd = texel_ops.pop_front();
        opcode <= wd.op;
        texel_index <= wd.index;
        texel_rgba <= wd.rgba;
        coord_u <= wd.u;
        coord_v <= wd.v;
        channel_select <= wd.chan;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) out_ready <= !rst && !take_break();

  // monitor: predict on input words, check output words
  always @(posedge clk) begin
    logic [LEVEL_W-1:0] want;
    in_taken = !rst && in_valid && in_ready;
    if (in_taken) begin
      words_taken++;
      if (opcode == OP_WRITE) begin
        texel_mem[texel_index] = texel_rgba;
        writes_taken++;
      end else begin
        expected_levels.push_back(bilinear_level(coord_u, coord_v, channel_select));
      end
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_levels.size() == 0) begin
        $display("%0t: level %h returned with no sample outstanding", $time, filtered_level);
        mismatches++;
      end else begin
        want = expected_levels.pop_front();
        if (filtered_level !== want) begin
          $display("%0t: level mismatch, expected %h actual %h", $time, want, filtered_level);
          mismatches++;
        end
        samples_checked++;
      end
    end
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run did not finish in %0d cycles", $time, CYCLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [DIM_W-1:0] widths [10];
    logic [DIM_W-1:0] heights [10];
    widths  = '{9'd4, 9'd1, 9'd0, 9'd511, 9'd2, 9'd256, 9'd17, 9'd256, 9'd300, 9'd0};
    heights = '{9'd3, 9'd1, 9'd0, 9'd300, 9'd256, 9'd1, 9'd9, 9'd256, 9'd257, 9'd5};
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset size: store corners, both edges, coordinates past 1.0
    queue_write('0, '1);
    queue_write('1, '0);
    queue_sample(17'h00000, 17'h10000, 2'd0);
    queue_sample(17'h10000, 17'h00000, 2'd3);
    queue_sample(17'h00000, 17'h00000, 2'd1);
    queue_sample(17'h1FFFF, 17'h1FFFF, 2'd2);
    queue_sample(17'h08000, 17'h08000, 2'd0);
    queue_sample(17'h0FFFF, 17'h00001, 2'd1);
    drain();
    queue_random(PHASE_WORDS);
    drain();

    for (int i = 0; i < 10; i++) begin
      // one full-size setting runs without any gaps or stalls
      steady = (i == 7);
      run_setting(widths[i], heights[i]);
    end
    steady = 1'b0;
    repeat (2) run_setting(DIM_W'($urandom_range(1, 16)), DIM_W'($urandom_range(1, 16)));

    $display("%0d samples checked, %0d texel writes, across %0d texture sizes",
             samples_checked, writes_taken, settings_run);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
